### rtl/mil_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mil_pkg: shared types, codes and AES helpers for the MILENAGE authenticator
// Payload structs, register indexes, status codes, S-box and round functions.
// ----------------------------------------------------------------------------
package mil_pkg;

	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 64;

	localparam logic [CfgIdxW-1:0] REG_KEY_HIGH  = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_KEY_LOW   = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_OPC_HIGH  = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_OPC_LOW   = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_SQN       = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_AMF       = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_AKA_EN    = 3'd6;

	localparam logic [1:0] ST_SUCCESS   = 2'd0;
	localparam logic [1:0] ST_SYNC_FAIL = 2'd1;
	localparam logic [1:0] ST_MAC_FAIL  = 2'd2;
	localparam logic [1:0] ST_NOT_SUPP  = 2'd3;

	typedef struct packed {
		logic [63:0] challenge_high;
		logic [63:0] challenge_low;
		logic [63:0] token_high;
		logic [63:0] token_low;
	} mil_in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] response;
		logic [63:0] cipher_key_high;
		logic [63:0] cipher_key_low;
		logic [63:0] integrity_key_high;
		logic [63:0] integrity_key_low;
		logic [63:0] resync_token_high;
		logic [47:0] resync_token_low;
	} mil_out_t;

	typedef struct packed {
		logic load;
		logic step;
	} aes_ctl_t;

	function automatic logic [7:0] xt(input logic [7:0] a);
		xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] sbox(input logic [7:0] x);
		logic [7:0] t [0:255];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		sbox = t[x];
	endfunction

	// byte 0 sits in bits [127:120]
	function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
		input logic last);
		logic [7:0] b [0:15];
		logic [7:0] u [0:15];
		logic [7:0] a0, a1, a2, a3, t;
		logic [127:0] r;
		for (int i = 0; i < 16; i++) begin
			b[i] = sbox(s[127-8*i -: 8]);
		end
		for (int c = 0; c < 4; c++) begin
			for (int i = 0; i < 4; i++) begin
				u[i+4*c] = b[i+4*((c+i)%4)];
			end
		end
		if (!last) begin
			for (int c = 0; c < 4; c++) begin
				a0 = u[4*c]; a1 = u[4*c+1]; a2 = u[4*c+2]; a3 = u[4*c+3];
				t = a0 ^ a1 ^ a2 ^ a3;
				u[4*c]   = a0 ^ t ^ xt(a0 ^ a1);
				u[4*c+1] = a1 ^ t ^ xt(a1 ^ a2);
				u[4*c+2] = a2 ^ t ^ xt(a2 ^ a3);
				u[4*c+3] = a3 ^ t ^ xt(a3 ^ a0);
			end
		end
		for (int i = 0; i < 16; i++) begin
			r[127-8*i -: 8] = u[i];
		end
		aes_round = r ^ rk;
	endfunction

	function automatic logic [127:0] key_next(input logic [127:0] k, input logic [7:0] rc);
		logic [31:0] w0, w1, w2, w3, t;
		w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
		t = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
		w0 = w0 ^ t;
		w1 = w1 ^ w0;
		w2 = w2 ^ w1;
		w3 = w3 ^ w2;
		key_next = {w0, w1, w2, w3};
	endfunction

endpackage
`default_nettype wire

### rtl/mil_aes_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mil_aes_core: iterative AES-128 encryption, one round per cycle while step is high
// Round keys are derived on the fly; done pulses after the tenth round.
// ----------------------------------------------------------------------------
module mil_aes_core
	import mil_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire aes_ctl_t     ctl,
	input  wire logic [127:0] key,
	input  wire logic [127:0] din,
	output logic              done,
	output logic [127:0]      dout
);

	logic [127:0] st_q;
	logic [127:0] rk_q;
	logic [7:0]   rc_q;
	logic [3:0]   rnd_q;
	logic         run_q;
	logic [127:0] rk_n;

	assign rk_n = key_next(rk_q, rc_q);
	assign dout = st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			rnd_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= !ctl.load && run_q && ctl.step && (rnd_q == 4'd10);
			if (ctl.load) begin
				run_q <= 1'b1;
				rnd_q <= 4'd1;
			end else if (run_q && ctl.step) begin
				if (rnd_q == 4'd10) begin
					run_q <= 1'b0;
				end
				rnd_q <= rnd_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			st_q <= din ^ key;
			rk_q <= key;
			rc_q <= 8'h01;
		end else if (run_q && ctl.step) begin
			st_q <= aes_round(st_q, rk_n, rnd_q == 4'd10);
			rk_q <= rk_n;
			rc_q <= xt(rc_q);
		end
	end

`ifndef ASSERT_OFF
	a_no_load_while_run: assert property (@(posedge clk) disable iff (!arst_n)
		run_q && !done |-> !ctl.load) else $error("aes reload mid-run");
	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held");
	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done) |-> $past(rnd_q) == 4'd10) else $error("early done");
`endif

endmodule
`default_nettype wire

### rtl/milenage_aka_authenticator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// milenage_aka_authenticator_core: MILENAGE AKA check over AES-128
// Runs TEMP, f2/f5, then f5*+f1* or f1 (+f3+f4 on a MAC match) on one shared AES core.
// ----------------------------------------------------------------------------
// channel  | signals                         | transfer
// request  | start, busy, req                | start && !busy
// result   | res_valid, res                  | res_valid (one cycle)
// config   | cfg_valid, cfg_ready, cfg_index | cfg_valid && cfg_ready
//
// Each AES pass is a load, ten rounds and done. Success runs 5 passes, sync failure 4,
// MAC failure 3; no AES pass runs when AKA is disabled. The passes run in turn on
// the single AES core.
// busy is high from acceptance until the result strobe.
// Reset clears the config registers and the sequencer; no stalls on the result side.
// ----------------------------------------------------------------------------
module milenage_aka_authenticator_core
	import mil_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire mil_in_t             req,
	output logic                     res_valid,
	output mil_out_t                 res,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_data
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LOAD = 3'd1;
	localparam logic [2:0] S_WAIT = 3'd2;
	localparam logic [2:0] S_DONE = 3'd3;

	localparam logic [2:0] F_TEMP = 3'd0;
	localparam logic [2:0] F_F2   = 3'd1;
	localparam logic [2:0] F_F5S  = 3'd2;
	localparam logic [2:0] F_F1S  = 3'd3;
	localparam logic [2:0] F_F1   = 3'd4;
	localparam logic [2:0] F_F3   = 3'd5;
	localparam logic [2:0] F_F4   = 3'd6;

	logic [127:0] key_q, opc_q;
	logic [47:0]  sqn_q;
	logic [15:0]  amf_q;
	logic         en_q;

	logic [2:0]   st_q, fn_q;
	mil_in_t      req_q;
	logic [127:0] temp_q, out2_q, ck_q;
	logic [47:0]  out5_q;
	logic [127:0] aes_in, aes_out, fo, top, in1, in1s, rot;
	logic         aes_done;
	aes_ctl_t     ctl;
	mil_out_t     res_init;

	assign cfg_ready = 1'b1;
	assign busy = st_q != S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0; opc_q <= '0; sqn_q <= '0; amf_q <= '0; en_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_KEY_HIGH: key_q[127:64] <= cfg_data;
				REG_KEY_LOW:  key_q[63:0]   <= cfg_data;
				REG_OPC_HIGH: opc_q[127:64] <= cfg_data;
				REG_OPC_LOW:  opc_q[63:0]   <= cfg_data;
				REG_SQN:      sqn_q         <= cfg_data[47:0];
				REG_AMF:      amf_q         <= cfg_data[15:0];
				REG_AKA_EN:   en_q          <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign top  = temp_q ^ opc_q;
	assign in1  = {sqn_q, amf_q, sqn_q, amf_q};
	assign in1s = {sqn_q, 16'h0, sqn_q, 16'h0};

	always_comb begin
		rot = '0;
		case (fn_q)
			F_TEMP: aes_in = {req_q.challenge_high, req_q.challenge_low} ^ opc_q;
			F_F2:   aes_in = top ^ 128'h1;
			F_F5S: begin
				rot = {top[31:0], top[127:32]};
				aes_in = rot ^ 128'h8;
			end
			F_F1S: begin
				rot = in1s ^ opc_q;
				aes_in = {rot[63:0], rot[127:64]} ^ temp_q;
			end
			F_F1: begin
				rot = in1 ^ opc_q;
				aes_in = {rot[63:0], rot[127:64]} ^ temp_q;
			end
			F_F3:   aes_in = {top[95:0], top[127:96]} ^ 128'h2;
			F_F4:   aes_in = {top[63:0], top[127:64]} ^ 128'h4;
			default: aes_in = '0;
		endcase
	end

	always_comb begin
		res_init = '0;
		res_init.status = en_q ? ST_SUCCESS : ST_NOT_SUPP;
	end

	assign ctl = '{load: st_q == S_LOAD, step: st_q == S_WAIT};
	assign fo = aes_out ^ opc_q;

	mil_aes_core u_aes (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .key(key_q), .din(aes_in),
		.done(aes_done), .dout(aes_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			fn_q <= F_TEMP;
			res_valid <= 1'b0;
		end else begin
			res_valid <= st_q == S_DONE;
			case (st_q)
				S_IDLE: begin
					if (start) begin
						fn_q <= F_TEMP;
						st_q <= en_q ? S_LOAD : S_DONE;
					end
				end
				S_LOAD: st_q <= S_WAIT;
				S_WAIT: begin
					if (aes_done) begin
						case (fn_q)
							F_TEMP: begin
								fn_q <= F_F2;
								st_q <= S_LOAD;
							end
							F_F2: begin
								fn_q <= ((req_q.token_high[63:16] ^ fo[127:80]) != sqn_q)
									? F_F5S : F_F1;
								st_q <= S_LOAD;
							end
							F_F5S: begin
								fn_q <= F_F1S;
								st_q <= S_LOAD;
							end
							F_F1: begin
								if ({sqn_q ^ out2_q[127:80], amf_q, fo[127:64]} !=
									{req_q.token_high, req_q.token_low}) begin
									st_q <= S_DONE;
								end else begin
									fn_q <= F_F3;
									st_q <= S_LOAD;
								end
							end
							F_F3: begin
								fn_q <= F_F4;
								st_q <= S_LOAD;
							end
							default: st_q <= S_DONE;
						endcase
					end
				end
				S_DONE: st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && start) begin
			req_q <= req;
			res <= res_init;
		end
		if (st_q == S_WAIT && aes_done) begin
			case (fn_q)
				F_TEMP: temp_q <= aes_out;
				F_F2:   out2_q <= fo;
				F_F5S:  out5_q <= fo[127:80];
				F_F1S: begin
					res.status <= ST_SYNC_FAIL;
					res.resync_token_high <= {sqn_q ^ out5_q, fo[63:48]};
					res.resync_token_low  <= fo[47:0];
				end
				F_F1:   res.status <= ST_MAC_FAIL;
				F_F3:   ck_q <= fo;
				F_F4: begin
					res.status <= ST_SUCCESS;
					res.response <= out2_q[63:0];
					res.cipher_key_high <= ck_q[127:64];
					res.cipher_key_low <= ck_q[63:0];
					res.integrity_key_high <= fo[127:64];
					res.integrity_key_low <= fo[63:0];
				end
				default: ;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("start not taken");
	a_result_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !busy) else $error("result while busy");
	a_result_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> !res_valid) else $error("result held");
`endif

endmodule
`default_nettype wire
